// ===== src/rtnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser package
// Shared types, constants and helper functions for the ringtone note parser.
// ----------------------------------------------------------------------------
package rtnp_pkg;

   localparam int CHAR_WIDTH     = 8;
   localparam int FREQ_WIDTH     = 19;
   localparam int LEN_WIDTH      = 17;
   localparam int BASE_WIDTH     = 16;
   localparam int DUR_WIDTH      = 8;
   localparam int NUM_WIDTH      = 23;
   localparam int DEN_WIDTH      = 18;
   localparam int COUNT_WIDTH    = $clog2(NUM_WIDTH);
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_DURATION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEFAULT_OCTAVE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BEATS_PER_MINUTE = 2'd2;

   localparam logic [5:0] RESET_DEFAULT_DURATION = 6'd4;
   localparam logic [2:0] RESET_DEFAULT_OCTAVE   = 3'd6;
   localparam logic [9:0] RESET_BEATS_PER_MINUTE = 10'd63;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CASE_OFFSET  = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] SHARP_STEP   = 8'd7;

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = 17'h1FFFF;
   localparam logic [LEN_WIDTH-1:0] NUM_PLAIN  = 17'd60000;
   localparam logic [LEN_WIDTH-1:0] NUM_DOTTED = 17'd90000;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_in;
      logic                  end_of_song;
   } req_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0] freq_centihz;
      logic [LEN_WIDTH-1:0]  length_ms;
      logic                  is_rest;
      logic                  final_note;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] dur_low_digit;
      logic [CHAR_WIDTH-1:0] dur_high_digit;
      logic [CHAR_WIDTH-1:0] note_code;
      logic [CHAR_WIDTH-1:0] octave_digit;
      logic                  dotted_flag;
   } fields_type;

   localparam fields_type FIELDS_EMPTY = '{
      dur_low_digit:  CHAR_ZERO,
      dur_high_digit: CHAR_ZERO,
      note_code:      CHAR_ZERO,
      octave_digit:   CHAR_ZERO,
      dotted_flag:    1'b0
   };

   typedef enum logic [1:0] {
      RTNP_IDLE,
      RTNP_LOAD,
      RTNP_DIVIDE,
      RTNP_WRITE
   } state_type;

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_letter(input logic [CHAR_WIDTH-1:0] c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
   endfunction

   // The character v is classified by the character nxt that follows it.
   function automatic fields_type classify(input fields_type f,
                                           input logic [CHAR_WIDTH-1:0] v,
                                           input logic [CHAR_WIDTH-1:0] nxt);
      fields_type r;
      r = f;
      if (is_digit(v) && is_letter(nxt)) begin
         r.dur_low_digit = v;
      end else if (is_digit(v) && is_digit(nxt)) begin
         r.dur_high_digit = v;
      end else if (is_letter(v)) begin
         r.note_code = v;
      end else if (is_digit(v)) begin
         r.octave_digit = v;
      end else if (v == CHAR_HASH) begin
         r.note_code = f.note_code + SHARP_STEP;
      end else if (v == CHAR_DOT) begin
         r.dotted_flag = 1'b1;
      end
      return r;
   endfunction

   // Octave four frequency in centihertz, zero for a rest or unknown code.
   function automatic logic [BASE_WIDTH-1:0] note_base(input logic [CHAR_WIDTH-1:0] code);
      logic [CHAR_WIDTH-1:0]  c;
      logic [BASE_WIDTH-1:0]  b;
      c = code;
      if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
         c = c + CASE_OFFSET;
      end
      case (c)
         "c": b = 16'd26163;
         "j": b = 16'd27718;
         "d": b = 16'd29366;
         "k": b = 16'd31113;
         "e": b = 16'd32963;
         "f": b = 16'd34923;
         "m": b = 16'd36999;
         "g": b = 16'd39200;
         "n": b = 16'd41530;
         "a": b = 16'd44000;
         "h": b = 16'd46616;
         "b": b = 16'd49388;
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

// ===== src/ringtone_note_parser.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser
// Parses ringtone note text one character per request and emits one note
// (frequency and length) for each comma or final character.
// ----------------------------------------------------------------------------
// A character that does not close a note is taken in the idle state, which
// it does not leave. A comma or a character flagged as the end of the song
// closes the note, which then passes the states LOAD, DIVIDE and WRITE: LOAD
// forms the frequency and the divisor, in DIVIDE the shared subtractor of
// the divider yields the quotient bits one at a time until the sequencer
// sees the divider finish, and WRITE loads the result into the output
// register. No request is taken meanwhile, so the next character is taken
// only back in idle, and later still while the output register is full. A
// character may be taken while an earlier note still waits at the output.
module ringtone_note_parser
   import rtnp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   state_type             state_ff, state_in;
   fields_type            fields_ff, fields_in;
   logic [CHAR_WIDTH-1:0] held_char_ff, held_char_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  final_ff, final_in;
   logic [FREQ_WIDTH-1:0] freq_ff, freq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [5:0]            default_duration_ff;
   logic [2:0]            default_octave_ff;
   logic [9:0]            beats_per_minute_ff;

   logic                  accept;
   logic                  is_comma;
   logic                  closes_note;
   logic                  div_start;
   logic                  div_done;
   logic                  rsp_load;
   logic [NUM_WIDTH-1:0]  quotient;
   logic [NUM_WIDTH-1:0]  numerator;
   logic [DEN_WIDTH-1:0]  denominator;
   logic [LEN_WIDTH-1:0]  length_ms;
   fields_type            fields_held;
   fields_type            fields_closed;
   logic [DUR_WIDTH-1:0]  dur_low;
   logic [DUR_WIDTH-1:0]  dur_high;
   logic [DUR_WIDTH-1:0]  dur;
   logic [CHAR_WIDTH-1:0] octave;
   logic [BASE_WIDTH-1:0] base;

   assign accept      = req_valid && req_ready;
   assign is_comma    = req_data.char_in == CHAR_COMMA;
   assign closes_note = is_comma || req_data.end_of_song;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RTNP_IDLE: begin
            if (accept && closes_note) begin
               state_in = RTNP_LOAD;
            end
         end
         RTNP_LOAD: begin
            state_in = RTNP_DIVIDE;
         end
         RTNP_DIVIDE: begin
            if (div_done) begin
               state_in = RTNP_WRITE;
            end
         end
         RTNP_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = RTNP_IDLE;
            end
         end
         default: begin
            state_in = RTNP_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         RTNP_IDLE:   req_ready = 1'b1;
         RTNP_LOAD:   div_start = 1'b1;
         RTNP_DIVIDE: ;
         RTNP_WRITE:  rsp_load = !rsp_valid_ff || rsp_ready;
         default:     ;
      endcase
   end

   always_comb begin
      fields_held   = held_valid_ff ? classify(fields_ff, held_char_ff, req_data.char_in)
                                    : fields_ff;
      fields_closed = (!is_comma && req_data.end_of_song)
                    ? classify(fields_held, req_data.char_in, CHAR_COMMA) : fields_held;

      dur_low  = (fields_ff.dur_low_digit == CHAR_ZERO) ? {2'b00, default_duration_ff}
                                                        : fields_ff.dur_low_digit - CHAR_ZERO;
      dur_high = fields_ff.dur_high_digit - CHAR_ZERO;
      dur      = (dur_high != '0) ? (dur_high << 3) + (dur_high << 1) + dur_low : dur_low;
      octave   = (fields_ff.octave_digit == CHAR_ZERO) ? {5'b00000, default_octave_ff}
                                                       : fields_ff.octave_digit - CHAR_ZERO;
      base     = note_base(fields_ff.note_code);

      denominator = DEN_WIDTH'(dur) * DEN_WIDTH'(beats_per_minute_ff);
      numerator   = NUM_WIDTH'(default_duration_ff) *
                    NUM_WIDTH'(fields_ff.dotted_flag ? NUM_DOTTED : NUM_PLAIN);

      case (octave)
         8'd5:    freq_in = {2'b00, base, 1'b0};
         8'd6:    freq_in = {1'b0, base, 2'b00};
         8'd7:    freq_in = {base, 3'b000};
         default: freq_in = {3'b000, base};
      endcase

      length_ms = (quotient[NUM_WIDTH-1:LEN_WIDTH] != '0) ? LEN_MAX
                                                         : quotient[LEN_WIDTH-1:0];

      fields_in     = fields_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      final_in      = final_ff;
      if (accept) begin
         fields_in = fields_closed;
         if (closes_note) begin
            final_in      = req_data.end_of_song;
            held_char_in  = '0;
            held_valid_in = 1'b0;
         end else begin
            held_char_in  = req_data.char_in;
            held_valid_in = 1'b1;
         end
      end else if (div_start) begin
         fields_in = FIELDS_EMPTY;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.freq_centihz = freq_ff;
         rsp_data_in.length_ms    = length_ms;
         rsp_data_in.is_rest      = freq_ff == '0;
         rsp_data_in.final_note   = final_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= RTNP_IDLE;
         fields_ff           <= FIELDS_EMPTY;
         held_char_ff        <= '0;
         held_valid_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         default_duration_ff <= RESET_DEFAULT_DURATION;
         default_octave_ff   <= RESET_DEFAULT_OCTAVE;
         beats_per_minute_ff <= RESET_BEATS_PER_MINUTE;
      end else begin
         state_ff      <= state_in;
         fields_ff     <= fields_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEFAULT_DURATION: default_duration_ff <= csr_wdata[5:0];
               CSR_DEFAULT_OCTAVE:   default_octave_ff   <= csr_wdata[2:0];
               CSR_BEATS_PER_MINUTE: beats_per_minute_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      final_ff    <= final_in;
      rsp_data_ff <= rsp_data_in;
      if (div_start) begin
         freq_ff <= freq_in;
      end
   end

   rtnp_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (numerator),
      .denominator (denominator),
      .done        (div_done),
      .quotient    (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == RTNP_DIVIDE)
      else $error("divider finished outside of the divide state");

   // A note only appears at the output from the write state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == RTNP_WRITE))
      else $error("note appeared without passing the write state");

   // The rest flag always agrees with the frequency it is sent with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_rest == (rsp_data_ff.freq_centihz == '0)))
      else $error("rest flag disagrees with frequency");

   // A closed note leaves no held character behind.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == RTNP_LOAD |-> !held_valid_ff)
      else $error("held character survived a closed note");

endmodule

// ===== src/rtnp_divider.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser divider
// Restoring divider that produces one quotient bit per cycle with a single
// shared subtractor.
// ----------------------------------------------------------------------------
module rtnp_divider
   import rtnp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] numerator,
   input  logic [DEN_WIDTH-1:0] denominator,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DEN_WIDTH-1:0]   rem_ff,   rem_in;
   logic [DEN_WIDTH-1:0]   den_ff,   den_in;
   logic [NUM_WIDTH-1:0]   quo_ff,   quo_in;

   logic [DEN_WIDTH:0] trial;
   logic [DEN_WIDTH:0] diff;
   logic               borrow;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_WIDTH-1]};
      diff   = trial - {1'b0, den_ff};
      borrow = diff[DEN_WIDTH];

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = COUNT_WIDTH'(NUM_WIDTH - 1);
         rem_in   = '0;
         den_in   = denominator;
         quo_in   = numerator;
      end else if (busy_ff) begin
         rem_in   = borrow ? trial[DEN_WIDTH-1:0] : diff[DEN_WIDTH-1:0];
         quo_in   = {quo_ff[NUM_WIDTH-2:0], ~borrow};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== tb/tb_ringtone_note_parser.sv =====
// ----------------------------------------------------------------------------
// Ringtone note parser testbench
// Streams ringtone note text into the parser under several register settings
// and idle patterns. Every accepted request updates a parser model kept here,
// and each closed note is matched field by field against the notes emitted.
// ----------------------------------------------------------------------------
module tb_ringtone_note_parser;
   import rtnp_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Parser model state.
   logic [5:0] cfg_dur;
   logic [2:0] cfg_oct;
   logic [9:0] cfg_bpm;
   logic [7:0] pend_char;
   logic       pend_valid;
   logic [7:0] low_digit;
   logic [7:0] high_digit;
   logic [7:0] note_char;
   logic [7:0] octave_char;
   logic       dotted;
   rsp_type    expected_notes[$];

   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    rsp_hold_cycles = 0;
   int    chars_sent = 0;
   int    mismatch_count = 0;
   int    quiet_cycles = 0;
   string note_letters = "cjdkefmgnahbp";
   string noise_chars = "0123456789#., aZ~";

   ringtone_note_parser dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit is_num(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic void clear_fields();
      low_digit   = CHAR_ZERO;
      high_digit  = CHAR_ZERO;
      note_char   = CHAR_ZERO;
      octave_char = CHAR_ZERO;
      dotted      = 1'b0;
      pend_char   = 8'h00;
      pend_valid  = 1'b0;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [CSR_DATA_WIDTH-1:0] val);
      case (idx)
         CSR_DEFAULT_DURATION: begin
            cfg_dur = val[5:0];
         end
         CSR_DEFAULT_OCTAVE: begin
            cfg_oct = val[2:0];
         end
         CSR_BEATS_PER_MINUTE: begin
            cfg_bpm = val;
         end
         default: begin
         end
      endcase
   endfunction

   // A held character is classified by the character that follows it.
   function automatic void absorb_char(input logic [7:0] v, input logic [7:0] nxt);
      if (is_num(v) && is_alpha(nxt)) begin
         low_digit = v;
      end else if (is_num(v) && is_num(nxt)) begin
         high_digit = v;
      end else if (is_alpha(v)) begin
         note_char = v;
      end else if (is_num(v)) begin
         octave_char = v;
      end else if (v == CHAR_HASH) begin
         note_char = note_char + SHARP_STEP;
      end else if (v == CHAR_DOT) begin
         dotted = 1'b1;
      end
   endfunction

   function automatic int unsigned pitch_centihz(input logic [7:0] code,
                                                 input int unsigned oct);
      logic [7:0]  lc;
      int unsigned f;
      lc = ((code >= "A") && (code <= "Z")) ? code + CASE_OFFSET : code;
      case (lc)
         "c": f = 26163;
         "j": f = 27718;
         "d": f = 29366;
         "k": f = 31113;
         "e": f = 32963;
         "f": f = 34923;
         "m": f = 36999;
         "g": f = 39200;
         "n": f = 41530;
         "a": f = 44000;
         "h": f = 46616;
         "b": f = 49388;
         default: f = 0;
      endcase
      if (oct == 5) begin
         f = f * 2;
      end else if (oct == 6) begin
         f = f * 4;
      end else if (oct == 7) begin
         f = f * 8;
      end
      return f;
   endfunction

   function automatic void close_note(input bit final_flag);
      int unsigned oct;
      int unsigned low;
      int unsigned high;
      int unsigned dur;
      int unsigned den;
      int unsigned num;
      int unsigned len;
      int unsigned f;
      rsp_type     note;
      oct  = (octave_char == CHAR_ZERO) ? cfg_oct : octave_char - CHAR_ZERO;
      low  = (low_digit == CHAR_ZERO) ? cfg_dur : low_digit - CHAR_ZERO;
      high = high_digit - CHAR_ZERO;
      dur  = (high != 0) ? high * 10 + low : low;
      f    = pitch_centihz(note_char, oct);
      den  = dur * cfg_bpm;
      num  = cfg_dur * (dotted ? 90000 : 60000);
      if (den == 0) begin
         len = LEN_MAX;
      end else begin
         len = num / den;
         if (len > LEN_MAX) begin
            len = LEN_MAX;
         end
      end
      note.freq_centihz = f[FREQ_WIDTH-1:0];
      note.length_ms    = len[LEN_WIDTH-1:0];
      note.is_rest      = (f == 0);
      note.final_note   = final_flag;
      expected_notes.push_back(note);
      clear_fields();
   endfunction

   function automatic void predict_char(input logic [7:0] c, input bit last);
      if (pend_valid) begin
         absorb_char(pend_char, c);
      end
      if (c == CHAR_COMMA) begin
         close_note(last);
      end else if (last) begin
         absorb_char(c, CHAR_COMMA);
         close_note(1'b1);
      end else begin
         pend_char  = c;
         pend_valid = 1'b1;
      end
   endfunction

   function automatic void note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input bit last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_in: c, end_of_song: last};
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_char(c, last);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit ends_song);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], ends_song && (i == s.len() - 1));
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      apply_reg(idx, val);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] dur_val,
                            input logic [CSR_DATA_WIDTH-1:0] oct_val,
                            input logic [CSR_DATA_WIDTH-1:0] bpm_val);
      write_reg(CSR_DEFAULT_DURATION, dur_val);
      write_reg(CSR_DEFAULT_OCTAVE, oct_val);
      write_reg(CSR_BEATS_PER_MINUTE, bpm_val);
   endtask

   task automatic drain_notes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_notes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One note in ringtone order with random content: duration, letter, sharps,
   // dots and octave, each present or not.
   task automatic send_note(input bit ends_song);
      logic [7:0] text[$];
      logic [7:0] letter;
      repeat ($urandom_range(0, 3)) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(19) != 0) begin
         if ($urandom_range(3) == 0) begin
            letter = CHAR_LOWER_A + 8'($urandom_range(0, 25));
         end else begin
            letter = note_letters[$urandom_range(0, note_letters.len() - 1)];
         end
         if ($urandom_range(9) < 3) begin
            letter = letter - CASE_OFFSET;
         end
         text.push_back(letter);
      end
      if ($urandom_range(29) == 0) begin
         repeat ($urandom_range(20, 40)) text.push_back(CHAR_HASH);
      end else if ($urandom_range(3) == 0) begin
         text.push_back(CHAR_HASH);
      end
      if ($urandom_range(4) == 0) begin
         text.push_back(CHAR_DOT);
      end
      if ($urandom_range(9) < 7) begin
         text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(6) == 0) begin
         text.push_back(CHAR_DOT);
      end
      if (!ends_song || text.size() == 0 || $urandom_range(1) == 0) begin
         text.push_back(CHAR_COMMA);
      end
      foreach (text[i]) begin
         send_char(text[i], ends_song && (i == text.size() - 1));
      end
   endtask

   task automatic send_noise();
      logic [7:0] c;
      int         n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1) == 1) begin
            c = 8'($urandom_range(0, 255));
         end else begin
            c = noise_chars[$urandom_range(0, noise_chars.len() - 1)];
         end
         send_char(c, (i == n - 1) && ($urandom_range(9) == 0));
      end
   endtask

   task automatic run_traffic(input int n);
      int stop_at;
      int pick;
      stop_at = chars_sent + n;
      while (chars_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 82) begin
            send_note(1'b0);
         end else if (pick < 94) begin
            send_noise();
         end else begin
            send_note(1'b1);
         end
      end
      send_note(1'b1);
      drain_notes();
   endtask

   task automatic test_directed_notes();
      send_text("16C#.7,", 1'b0);
      send_text("p,", 1'b0);
      send_text("10b,", 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("h5", 1'b0);
      send_char(CHAR_COMMA, 1'b1);
      send_char("e", 1'b1);
      send_text("2g4", 1'b1);
      drain_notes();
   endtask

   task automatic test_reset_settings();
      run_traffic(100);
   endtask

   task automatic test_low_settings();
      configure(10'd1, 10'd4, 10'd25);
      run_traffic(150);
   endtask

   task automatic test_high_settings();
      configure(10'd32, 10'd7, 10'd900);
      run_traffic(150);
   endtask

   task automatic test_register_widths();
      configure(10'h3FF, 10'h3FF, 10'h3FF);
      write_reg(CSR_UNUSED, 10'($urandom_range(0, 1023)));
      run_traffic(100);
   endtask

   task automatic test_zero_divisor();
      configure(10'd0, 10'd0, 10'd0);
      run_traffic(40);
      write_reg(CSR_BEATS_PER_MINUTE, 10'd100);
      run_traffic(40);
   endtask

   task automatic test_length_saturation();
      configure(10'd40, 10'd5, 10'd1);
      run_traffic(100);
   endtask

   task automatic test_output_backpressure();
      configure(10'd8, 10'd5, 10'd120);
      rsp_hold_cycles = 300;
      run_traffic(80);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         configure(10'($urandom_range(1, 32)), 10'($urandom_range(4, 7)),
                   10'($urandom_range(25, 900)));
         run_traffic(60);
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : note_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_notes.size() == 0) begin
            note_error($sformatf("unexpected note: expected none, got freq %0d len %0d",
                                 rsp_data.freq_centihz, rsp_data.length_ms));
         end else begin
            want = expected_notes.pop_front();
            if (rsp_data.freq_centihz !== want.freq_centihz) begin
               note_error($sformatf("freq_centihz: expected %0d, got %0d",
                                    want.freq_centihz, rsp_data.freq_centihz));
            end
            if (rsp_data.length_ms !== want.length_ms) begin
               note_error($sformatf("length_ms: expected %0d, got %0d",
                                    want.length_ms, rsp_data.length_ms));
            end
            if (rsp_data.is_rest !== want.is_rest) begin
               note_error($sformatf("is_rest: expected %0b, got %0b",
                                    want.is_rest, rsp_data.is_rest));
            end
            if (rsp_data.final_note !== want.final_note) begin
               note_error($sformatf("final_note: expected %0b, got %0b",
                                    want.final_note, rsp_data.final_note));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ringtone_note_parser verification failed");
         $finish;
      end
   end

   initial begin
      cfg_dur = RESET_DEFAULT_DURATION;
      cfg_oct = RESET_DEFAULT_OCTAVE;
      cfg_bpm = RESET_BEATS_PER_MINUTE;
      clear_fields();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 66;
      test_directed_notes();
      test_reset_settings();
      test_low_settings();

      send_idle_pct = 66;
      recv_idle_pct = 23;
      test_high_settings();
      test_register_widths();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_zero_divisor();
      test_length_saturation();
      test_output_backpressure();
      test_random_settings();

      if (mismatch_count == 0) begin
         $display("ringtone_note_parser verification clean");
      end else begin
         $display("ringtone_note_parser verification failed");
      end
      $finish;
   end

endmodule
